>>> rtl/core/mi4_pkg.sv
// mi4_pkg: shared types, constants and the operation decoder of the 4x4 matrix inverse.
// Used by mi4_calc; no dependencies.
package mi4_pkg;

   typedef enum logic [1:0] {
      PH_EMIN,
      PH_COF,
      PH_DET
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDX,
      ST_RDM,
      ST_LDM,
      ST_MUL,
      ST_DRD,
      ST_DST,
      ST_DWAIT,
      ST_PUSH
   } state_type;

   // wide scratch layout: 2x2 minors at 0..5, cofactors at T_BASE..T_BASE+15
   localparam logic [4:0] T_BASE    = 5'd6;
   localparam int         WIDE_DEPTH = 22;
   localparam logic [2:0] E_LAST    = 3'd5;
   localparam logic [2:0] T_LAST    = 3'd7;
   localparam logic [2:0] DET_LAST  = 3'd3;
   localparam logic [1:0] TERM_LAST = 2'd2;
   localparam logic [3:0] POS_LAST  = 4'd15;

   typedef struct packed {
      logic [3:0] m_idx;   // element that drives the multiplier, column-major
      logic       x_elem;  // multiplicand is an element, else a wide scratch value
      logic [4:0] x_idx;
      logic       sub;
      logic       first;   // clear the accumulator before this product
   } op_type;

   function automatic op_type op_decode(phase_type ph, logic set, logic [2:0] idx,
                                        logic [1:0] term);
      op_type     op;
      logic [1:0] ca;
      logic [1:0] cb;
      logic [1:0] p;
      logic [1:0] q;
      logic [1:0] row;
      logic [1:0] col;
      logic [2:0] ex;
      logic       neg;
      logic       sub2;
      op   = '0;
      ca   = 2'd0;
      cb   = 2'd1;
      col  = 2'd0;
      ex   = 3'd0;
      sub2 = 1'b0;
      p    = {~set, 1'b0};
      q    = {~set, 1'b1};
      row  = {set, ~idx[2]};
      neg  = idx[0] ^ idx[2];
      unique case (ph)
         PH_EMIN: begin
            unique case (idx)
               3'd0: begin ca = 2'd0; cb = 2'd1; end
               3'd1: begin ca = 2'd0; cb = 2'd2; end
               3'd2: begin ca = 2'd1; cb = 2'd2; end
               3'd3: begin ca = 2'd1; cb = 2'd3; end
               3'd4: begin ca = 2'd2; cb = 2'd3; end
               default: begin ca = 2'd3; cb = 2'd0; end
            endcase
            op.x_elem = 1'b1;
            if (term == 2'd0) begin
               op.m_idx = {ca, p};
               op.x_idx = {1'b0, cb, q};
               op.first = 1'b1;
            end else begin
               op.m_idx = {ca, q};
               op.x_idx = {1'b0, cb, p};
               op.sub   = 1'b1;
            end
         end
         PH_COF: begin
            unique case ({idx[1:0], term})
               4'b00_00: begin col = 2'd1; ex = 3'd4; end
               4'b00_01: begin col = 2'd2; ex = 3'd3; sub2 = 1'b1; end
               4'b00_10: begin col = 2'd3; ex = 3'd2; end
               4'b01_00: begin col = 2'd0; ex = 3'd4; end
               4'b01_01: begin col = 2'd2; ex = 3'd5; end
               4'b01_10: begin col = 2'd3; ex = 3'd1; end
               4'b10_00: begin col = 2'd0; ex = 3'd3; end
               4'b10_01: begin col = 2'd1; ex = 3'd5; end
               4'b10_10: begin col = 2'd3; ex = 3'd0; end
               4'b11_00: begin col = 2'd0; ex = 3'd2; end
               4'b11_01: begin col = 2'd1; ex = 3'd1; sub2 = 1'b1; end
               4'b11_10: begin col = 2'd2; ex = 3'd0; end
               default: begin col = 2'd0; ex = 3'd0; end
            endcase
            op.m_idx = {col, row};
            op.x_idx = {2'b00, ex};
            op.sub   = sub2 ^ neg;
            op.first = (term == 2'd0);
         end
         PH_DET: begin
            op.m_idx = {idx[1:0], 2'b00};
            op.x_idx = T_BASE + {3'b000, idx[1:0]};
            op.first = (idx == 3'd0);
         end
         default: op = '0;
      endcase
      return op;
   endfunction

endpackage

>>> rtl/core/mi4_fifo.sv
// mi4_fifo: small synchronous queue with full/empty flags.
// Standalone; DEPTH must be a power of two.
module mi4_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= wdata;
      end
   end
endmodule

>>> rtl/core/mi4_front.sv
// mi4_front: accepts matrix elements into a two-bank element memory.
// Hands a finished bank to the back end through the bank queue; no package use.
module mi4_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [DATA_WIDTH-1:0] req_element,
   input  logic                  bank_full,
   output logic                  bank_push,
   output logic                  bank_id,
   input  logic [4:0]            rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);
   logic [DATA_WIDTH-1:0] mem [32];
   logic [3:0]            load_count_ff, load_count_in;
   logic                  wbank_ff, wbank_in;
   logic                  accept;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // both banks owned by the back end: hold off
   assign req_full  = bank_full;
   assign accept    = req_push & ~bank_full;
   assign bank_push = accept & (load_count_ff == 4'd15);
   assign bank_id   = wbank_ff;
   assign rd_data   = rd_data_ff;

   always_comb begin
      load_count_in = accept ? load_count_ff + 4'd1 : load_count_ff;
      wbank_in      = bank_push ? ~wbank_ff : wbank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         wbank_ff      <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         wbank_ff      <= wbank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[{wbank_ff, load_count_ff}] <= req_element;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

>>> rtl/core/mi4_div.sv
// mi4_div: restoring divider, one quotient bit per cycle, with saturation.
// Computes trunc(num * 2^(2*FRAC_BITS) / den) clipped to DATA_WIDTH signed bits.
module mi4_div #(
   parameter  int DATA_WIDTH = 32,
   parameter  int FRAC_BITS  = 16,
   localparam int W          = 4*DATA_WIDTH + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [W-1:0]          num,
   input  logic [W-1:0]          den,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quot
);
   localparam int DW = DATA_WIDTH;
   localparam int NW = W + 2*FRAC_BITS;
   localparam int XW = NW + DW;
   localparam int CW = $clog2(DW + 1);
   localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  den_ff, den_in;
   logic [DW-1:0] nlo_ff, nlo_in;
   logic [DW-1:0] q_ff, q_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] quot_ff, quot_in;

   logic [W-1:0]  nabs;
   logic [W-1:0]  dabs;
   logic [NW-1:0] nfull;
   logic [XW-1:0] nx;
   logic [XW-1:0] dx;
   logic          ovf;
   logic          neg;
   logic [W-1:0]  trial;
   logic          ge;

   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      nabs  = num[W-1] ? (~num + 1'b1) : num;
      dabs  = den[W-1] ? (~den + 1'b1) : den;
      nfull = {nabs, {(2*FRAC_BITS){1'b0}}};
      nx    = XW'(nfull);
      dx    = XW'(dabs) << DW;
      ovf   = (nx >= dx);
      neg   = num[W-1] ^ den[W-1];
      trial = {rem_ff[W-2:0], nlo_ff[DW-1]};
      ge    = (trial >= den_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      nlo_in  = nlo_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (start) begin
         neg_in = neg;
         den_in = dabs;
         nlo_in = nfull[DW-1:0];
         rem_in = W'(nx >> DW);
         q_in   = '0;
         if (ovf) begin
            done_in = 1'b1;
            quot_in = neg ? QMIN : QMAX;
         end else begin
            busy_in = 1'b1;
            cnt_in  = CW'(DW);
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? trial - den_ff : trial;
            q_in   = {q_ff[DW-2:0], ge};
            nlo_in = nlo_ff << 1;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               quot_in = q_ff[DW-1] ? QMAX : q_ff;
            end else begin
               quot_in = q_ff[DW-1] ? QMIN : (~q_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      nlo_ff  <= nlo_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end
endmodule

>>> rtl/core/mi4_calc.sv
// mi4_calc: back end sequencer; exact minors, cofactors and determinant with one
// shift-add multiplier, then one division per result unless singular. Uses mi4_pkg.
module mi4_calc #(
   parameter  int DATA_WIDTH = 32,
   localparam int W          = 4*DATA_WIDTH + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  bank_empty,
   input  logic                  bank_id,
   output logic                  bank_pop,
   output logic [4:0]            elem_rd_addr,
   input  logic [DATA_WIDTH-1:0] elem_rd_data,
   output logic                  div_start,
   output logic [W-1:0]          div_num,
   output logic [W-1:0]          div_den,
   input  logic                  div_done,
   input  logic [DATA_WIDTH-1:0] div_quot,
   input  logic                  out_full,
   output logic                  out_push,
   output logic [DATA_WIDTH+5:0] out_data
);
   localparam int DW = DATA_WIDTH;

   mi4_pkg::state_type state_ff, state_in;
   mi4_pkg::phase_type phase_ff, phase_in;
   logic          set_ff, set_in;
   logic [2:0]    idx_ff, idx_in;
   logic [1:0]    term_ff, term_in;
   logic [3:0]    k_ff, k_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  mcand_ff, mcand_in;
   logic [DW-1:0] mplier_ff, mplier_in;
   logic          msub_ff, msub_in;
   logic [W-1:0]  det_ff, det_in;
   logic [DW-1:0] res_ff, res_in;

   logic [W-1:0]  wmem [mi4_pkg::WIDE_DEPTH];
   logic [W-1:0]  wrd_ff;
   logic [4:0]    wr_raddr;
   logic [4:0]    wr_waddr;
   logic          wr_we;

   mi4_pkg::op_type op;
   logic          sing;
   logic [DW-1:0] mag;

   assign op       = mi4_pkg::op_decode(phase_ff, set_ff, idx_ff, term_ff);
   assign sing     = (det_ff == '0);
   assign mag      = elem_rd_data[DW-1] ? (~elem_rd_data + 1'b1) : elem_rd_data;
   assign div_num  = wrd_ff;
   assign div_den  = det_ff;
   assign out_data = {res_ff, k_ff, sing, k_ff == mi4_pkg::POS_LAST};

   always_comb begin
      elem_rd_addr = {bank_id, (state_ff == mi4_pkg::ST_RDX) ? op.x_idx[3:0] : op.m_idx};
      wr_raddr     = (state_ff == mi4_pkg::ST_DRD) ? mi4_pkg::T_BASE + {1'b0, k_ff}
                                                    : op.x_idx;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      set_in    = set_ff;
      idx_in    = idx_ff;
      term_in   = term_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      msub_in   = msub_ff;
      det_in    = det_ff;
      res_in    = res_ff;
      wr_we     = 1'b0;
      wr_waddr  = {2'b00, idx_ff};
      bank_pop  = 1'b0;
      div_start = 1'b0;
      out_push  = 1'b0;

      unique case (state_ff)
         mi4_pkg::ST_IDLE: begin
            if (!bank_empty) begin
               state_in = mi4_pkg::ST_RDX;
               phase_in = mi4_pkg::PH_EMIN;
               set_in   = 1'b0;
               idx_in   = '0;
               term_in  = '0;
            end
         end
         mi4_pkg::ST_RDX: state_in = mi4_pkg::ST_RDM;
         mi4_pkg::ST_RDM: begin
            mcand_in = op.x_elem ? {{(W-DW){elem_rd_data[DW-1]}}, elem_rd_data} : wrd_ff;
            state_in = mi4_pkg::ST_LDM;
         end
         mi4_pkg::ST_LDM: begin
            // magnitude drives the shifts, sign folds into add or subtract
            mplier_in = mag;
            msub_in   = op.sub ^ elem_rd_data[DW-1];
            if (op.first) begin
               acc_in = '0;
            end
            state_in = mi4_pkg::ST_MUL;
         end
         mi4_pkg::ST_MUL: begin
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + (mcand_ff ^ {W{msub_ff}}) + W'(msub_ff);
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               state_in = mi4_pkg::ST_RDX;
               unique case (phase_ff)
                  mi4_pkg::PH_EMIN: begin
                     if (term_ff == 2'd0) begin
                        term_in = 2'd1;
                     end else begin
                        wr_we    = 1'b1;
                        wr_waddr = {2'b00, idx_ff};
                        term_in  = '0;
                        if (idx_ff == mi4_pkg::E_LAST) begin
                           phase_in = mi4_pkg::PH_COF;
                           idx_in   = '0;
                        end else begin
                           idx_in = idx_ff + 3'd1;
                        end
                     end
                  end
                  mi4_pkg::PH_COF: begin
                     if (term_ff != mi4_pkg::TERM_LAST) begin
                        term_in = term_ff + 2'd1;
                     end else begin
                        wr_we    = 1'b1;
                        wr_waddr = mi4_pkg::T_BASE + {1'b0, set_ff, idx_ff};
                        term_in  = '0;
                        if (idx_ff == mi4_pkg::T_LAST) begin
                           idx_in = '0;
                           if (set_ff) begin
                              state_in = mi4_pkg::ST_DRD;
                              k_in     = '0;
                           end else begin
                              phase_in = mi4_pkg::PH_DET;
                           end
                        end else begin
                           idx_in = idx_ff + 3'd1;
                        end
                     end
                  end
                  mi4_pkg::PH_DET: begin
                     if (idx_ff == mi4_pkg::DET_LAST) begin
                        det_in   = acc_ff;
                        phase_in = mi4_pkg::PH_EMIN;
                        set_in   = 1'b1;
                        idx_in   = '0;
                     end else begin
                        idx_in = idx_ff + 3'd1;
                     end
                  end
                  default: state_in = mi4_pkg::ST_IDLE;
               endcase
            end
         end
         mi4_pkg::ST_DRD: begin
            if (sing) begin
               res_in   = '0;
               state_in = mi4_pkg::ST_PUSH;
            end else begin
               state_in = mi4_pkg::ST_DST;
            end
         end
         mi4_pkg::ST_DST: begin
            div_start = 1'b1;
            state_in  = mi4_pkg::ST_DWAIT;
         end
         mi4_pkg::ST_DWAIT: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = mi4_pkg::ST_PUSH;
            end
         end
         mi4_pkg::ST_PUSH: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (k_ff == mi4_pkg::POS_LAST) begin
                  bank_pop = 1'b1;
                  state_in = mi4_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = mi4_pkg::ST_DRD;
               end
            end
         end
         default: state_in = mi4_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mi4_pkg::ST_IDLE;
         phase_ff <= mi4_pkg::PH_EMIN;
         set_ff   <= 1'b0;
         idx_ff   <= '0;
         term_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         set_ff   <= set_in;
         idx_ff   <= idx_in;
         term_ff  <= term_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      msub_ff   <= msub_in;
      det_ff    <= det_in;
      res_ff    <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_we) begin
         wmem[wr_waddr] <= acc_ff;
      end
      wrd_ff <= wmem[wr_raddr];
   end
endmodule

>>> rtl/core/matrix_inverse_4x4.sv
// 4x4 matrix inverse by exact cofactors. Push the sixteen elements of a matrix in
// column-major order (signed Q format with FRAC_BITS fraction bits); after the
// sixteenth, sixteen results come out in column-major order, each the saturated
// truncated quotient of a cofactor by the determinant, or zero with singular set.
// Elements go in at one per cycle into one of two banks, so the next matrix loads
// while the current one is worked on; push stalls only when both banks are full.
// The back end runs one shift-add multiplier (one multiplier bit per cycle, ending
// early at the highest set bit) over 76 products, then one restoring divider for
// each result of a non-singular matrix.
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [DATA_WIDTH-1:0] req_element,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [DATA_WIDTH-1:0] rsp_inverse_value,
   output logic [3:0]            rsp_position,
   output logic                  rsp_singular,
   output logic                  rsp_last
);
   localparam int W = 4*DATA_WIDTH + 2;

   logic                  bank_push;
   logic                  bank_id_in;
   logic                  bank_full;
   logic                  bank_empty;
   logic                  bank_pop;
   logic                  bank_head;
   logic [4:0]            elem_rd_addr;
   logic [DATA_WIDTH-1:0] elem_rd_data;
   logic                  div_start;
   logic [W-1:0]          div_num;
   logic [W-1:0]          div_den;
   logic                  div_done;
   logic [DATA_WIDTH-1:0] div_quot;
   logic                  out_full;
   logic                  out_push;
   logic [DATA_WIDTH+5:0] out_data;
   logic [DATA_WIDTH+5:0] rsp_data;

   mi4_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_element (req_element),
      .bank_full   (bank_full),
      .bank_push   (bank_push),
      .bank_id     (bank_id_in),
      .rd_addr     (elem_rd_addr),
      .rd_data     (elem_rd_data)
   );

   mi4_fifo #(.WIDTH(1), .DEPTH(2)) u_bank_q (
      .clock (clock),
      .reset (reset),
      .push  (bank_push),
      .full  (bank_full),
      .wdata (bank_id_in),
      .pop   (bank_pop),
      .empty (bank_empty),
      .rdata (bank_head)
   );

   mi4_calc #(.DATA_WIDTH(DATA_WIDTH)) u_calc (
      .clock        (clock),
      .reset        (reset),
      .bank_empty   (bank_empty),
      .bank_id      (bank_head),
      .bank_pop     (bank_pop),
      .elem_rd_addr (elem_rd_addr),
      .elem_rd_data (elem_rd_data),
      .div_start    (div_start),
      .div_num      (div_num),
      .div_den      (div_den),
      .div_done     (div_done),
      .div_quot     (div_quot),
      .out_full     (out_full),
      .out_push     (out_push),
      .out_data     (out_data)
   );

   mi4_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   mi4_fifo #(.WIDTH(DATA_WIDTH+6), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_data),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_data)
   );

   assign rsp_inverse_value = rsp_data[DATA_WIDTH+5:6];
   assign rsp_position      = rsp_data[5:2];
   assign rsp_singular      = rsp_data[1];
   assign rsp_last          = rsp_data[0];
endmodule

>>> test/tb_matrix_inverse_4x4.sv
// Testbench for matrix_inverse_4x4: streams 4x4 matrices in column-major order and
// checks every inverse element against an exact wide-integer cofactor predictor or typed-in values.
// Depends on the RTL top level only.
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int NUM_RANDOM = 21;
   localparam int LONG_HOLD = 3000;
   localparam logic [DW-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [DW-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [DW-1:0] Q_MIN = 32'h8000_0000;

   typedef logic signed [255:0] wide_t;
   typedef logic [DW-1:0] mat_t [16];

   typedef struct {
      mat_t       elem;
      bit         typed;     // expected diagonal and singular typed in
      logic [DW-1:0] t_diag;
      bit         t_sing;
   } mat_job_t;

   typedef struct {
      logic [DW-1:0] value;
      logic [3:0]    position;
      logic          singular;
      logic          last;
   } inv_elem_t;

   logic          clock;
   logic          reset;
   logic          req_push;
   logic          req_full;
   logic [DW-1:0] req_element;
   logic          rsp_empty;
   logic          rsp_pop;
   logic [DW-1:0] rsp_inverse_value;
   logic [3:0]    rsp_position;
   logic          rsp_singular;
   logic          rsp_last;

   mat_job_t  send_q[$];
   mat_job_t  loaded_q[$];
   inv_elem_t inverse_q[$];
   mat_t      load_buf;
   int        load_idx;
   int        errors;
   int        matrices_done;
   int        singular_seen;
   int        results_seen;
   bit        send_done;
   bit        hold_request;

   matrix_inverse_4x4 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_element(req_element),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_inverse_value(rsp_inverse_value), .rsp_position(rsp_position),
      .rsp_singular(rsp_singular), .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   function automatic wide_t sx(logic [DW-1:0] v);
      return wide_t'(signed'(v));
   endfunction

   // element at row r, column c; rows/cols listed skip the removed ones
   function automatic wide_t minor3(mat_t m, int skip_r, int skip_c);
      wide_t a[3][3];
      int    rr;
      int    cc;
      rr = 0;
      for (int r = 0; r < 4; r++) begin
         if (r != skip_r) begin
            cc = 0;
            for (int c = 0; c < 4; c++) begin
               if (c != skip_c) begin
                  a[rr][cc] = sx(m[c*4+r]);
                  cc++;
               end
            end
            rr++;
         end
      end
      return a[0][0]*(a[1][1]*a[2][2] - a[1][2]*a[2][1])
           - a[0][1]*(a[1][0]*a[2][2] - a[1][2]*a[2][0])
           + a[0][2]*(a[1][0]*a[2][1] - a[1][1]*a[2][0]);
   endfunction

   function automatic wide_t cofactor(mat_t m, int r, int c);
      wide_t mn;
      mn = minor3(m, r, c);
      return ((r + c) % 2) ? -mn : mn;
   endfunction

   // exact adjugate over determinant, truncated and saturated
   task automatic predict_inverse(mat_t m);
      wide_t     det;
      wide_t     q;
      inv_elem_t e;
      det = '0;
      for (int c = 0; c < 4; c++) det += sx(m[c*4]) * cofactor(m, 0, c);
      for (int k = 0; k < 16; k++) begin
         e.position = 4'(k);
         e.last = (k == 15);
         e.singular = (det == 0);
         e.value = '0;
         if (det != 0) begin
            // inverse(r,c) = cofactor(c,r) / det
            q = (cofactor(m, k / 4, k % 4) <<< (2 * FB)) / det;
            if (q > sx(Q_MAX)) e.value = Q_MAX;
            else if (q < sx(Q_MIN)) e.value = Q_MIN;
            else e.value = q[DW-1:0];
         end
         inverse_q.push_back(e);
      end
      if (det == 0) singular_seen++;
   endtask

   task automatic push_typed(logic [DW-1:0] diag, bit sing);
      inv_elem_t e;
      for (int k = 0; k < 16; k++) begin
         e.position = 4'(k);
         e.last = (k == 15);
         e.singular = sing;
         e.value = (k % 5 == 0) ? diag : '0;
         inverse_q.push_back(e);
      end
      if (sing) singular_seen++;
   endtask

   function automatic mat_job_t diag_job(logic [DW-1:0] d, bit typed, logic [DW-1:0] t_diag,
                                         bit t_sing);
      mat_job_t j;
      for (int k = 0; k < 16; k++) j.elem[k] = (k % 5 == 0) ? d : '0;
      j.typed = typed;
      j.t_diag = t_diag;
      j.t_sing = t_sing;
      return j;
   endfunction

   function automatic mat_job_t random_job();
      mat_job_t j;
      int       mode;
      int       src;
      mode = $urandom_range(0, 9);
      j.typed = 0;
      for (int k = 0; k < 16; k++) begin
         case (mode)
            0, 1, 2, 3, 4: j.elem[k] = $urandom;
            5, 6: j.elem[k] = DW'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
            7: j.elem[k] = ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
            default: j.elem[k] = DW'($urandom_range(0, 7)) - 3;
         endcase
      end
      // duplicate a column now and then to force a zero determinant
      if (mode == 9 || $urandom_range(0, 9) == 0) begin
         src = $urandom_range(0, 3);
         for (int r = 0; r < 4; r++) j.elem[((src + 1) % 4) * 4 + r] = j.elem[src * 4 + r];
      end
      return j;
   endfunction

   // input side monitor: collect a matrix, predict on its sixteenth transfer
   always @(posedge clock) begin
      mat_job_t j;
      if (reset) begin
         load_idx <= 0;
      end else if (req_push && !req_full) begin
         load_buf[load_idx] = req_element;
         if (load_idx == 15) begin
            j = loaded_q.pop_front();
            if (j.typed) push_typed(j.t_diag, j.t_sing);
            else predict_inverse(load_buf);
            load_idx <= 0;
         end else begin
            load_idx <= load_idx + 1;
         end
      end
   end

   // result side checker
   always @(posedge clock) begin
      inv_elem_t e;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (inverse_q.size() == 0) begin
            $error("unexpected result at position %0d", rsp_position);
            errors++;
         end else begin
            e = inverse_q.pop_front();
            if (rsp_inverse_value !== e.value) begin
               $error("inverse_value: expected %h, got %h", e.value, rsp_inverse_value);
               errors++;
            end
            if (rsp_position !== e.position) begin
               $error("position: expected %0d, got %0d", e.position, rsp_position);
               errors++;
            end
            if (rsp_singular !== e.singular) begin
               $error("singular: expected %b, got %b", e.singular, rsp_singular);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %b, got %b", e.last, rsp_last);
               errors++;
            end
            if (e.last) matrices_done++;
         end
      end
   end

   // receiver: random gaps per transfer, plus one long hold on request
   initial begin
      int gap;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (hold_request) begin
            hold_request = 0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // sender
   initial begin
      mat_job_t j;
      int       gap;
      int       burst;
      req_push = 1'b0;
      req_element = '0;
      send_done = 0;
      hold_request = 0;
      errors = 0;
      matrices_done = 0;
      singular_seen = 0;
      results_seen = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, zero, smallest positive diagonal, smallest negative
      // diagonal (both saturate), then extremes checked by the predictor
      send_q.push_back(diag_job(Q_ONE, 1, Q_ONE, 0));
      send_q.push_back(diag_job('0, 1, '0, 1));
      send_q.push_back(diag_job(32'h1, 1, Q_MAX, 0));
      send_q.push_back(diag_job(32'hffff_ffff, 1, Q_MIN, 0));
      j = diag_job(Q_MAX, 0, '0, 0);
      for (int k = 0; k < 16; k++) if (k % 5 != 0) j.elem[k] = (k % 2) ? Q_MIN : Q_MAX;
      send_q.push_back(j);
      for (int i = 0; i < NUM_RANDOM; i++) send_q.push_back(random_job());

      for (int mi = 0; send_q.size() > 0; mi++) begin
         j = send_q.pop_front();
         loaded_q.push_back(j);
         if (mi == 8) hold_request = 1;
         burst = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 16; k++) begin
            gap = burst ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            req_push <= 1'b1;
            req_element <= j.elem[k];
            @(posedge clock);
            while (req_full) @(posedge clock);
         end
         if (mi == 14) begin
            // drain everything before going on
            req_push <= 1'b0;
            @(posedge clock);
            wait (inverse_q.size() == 0);
         end
      end
      req_push <= 1'b0;
      send_done = 1;
   end

   initial begin
      wait (send_done);
      @(posedge clock);
      wait (inverse_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d matrices, %0d results, %0d singular", matrices_done,
               results_seen, singular_seen);
      $display("directed identity/zero/saturation cases plus random and long-stall traffic");
      if (errors == 0 && inverse_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("timeout with %0d results outstanding", inverse_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/mi4_pkg.sv
rtl/core/mi4_fifo.sv
rtl/core/mi4_front.sv
rtl/core/mi4_div.sv
rtl/core/mi4_calc.sv
rtl/core/matrix_inverse_4x4.sv
test/tb_matrix_inverse_4x4.sv
